FILE: rtl/core/nacp_pkg.sv
`timescale 1ns / 1ps

package nacp_pkg;

  localparam int HDR_BYTES  = 24;
  localparam int UNIT_BYTES = 8;
  localparam int OFF_W      = 11;
  localparam int MAC_W      = 48;
  localparam int ADDR_W     = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] NA_TYPE   = 8'd136;
  localparam logic [7:0] NA_CODE   = 8'd0;
  localparam logic [7:0] TLLA_KIND = 8'd2;

  localparam logic [1:0] VERDICT_NOT_ADVERT = 2'd0;
  localparam logic [1:0] VERDICT_NO_OPTION  = 2'd1;
  localparam logic [1:0] VERDICT_OWN_MAC    = 2'd2;
  localparam logic [1:0] VERDICT_CONFLICT   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [MAC_W-1:0] peer_mac;
    logic             conflict_seen;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [ADDR_W-1:0]    wr_data;
  } cfg_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] target_addr_high;
    logic [ADDR_W-1:0] target_addr_low;
    logic [MAC_W-1:0]  local_mac;
  } cfg_regs_t;

endpackage

FILE: rtl/core/nacp_stream_if.sv
`timescale 1ns / 1ps

interface nacp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/nacp_cfg_regs.sv
`timescale 1ns / 1ps

module nacp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [nacp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [nacp_pkg::ADDR_W-1:0] wr_data,
  output nacp_pkg::cfg_regs_t         cfg
);
  import nacp_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_TARGET_HIGH: cfg_nxt.target_addr_high = wr_data;
        REG_TARGET_LOW:  cfg_nxt.target_addr_low  = wr_data;
        REG_LOCAL_MAC:   cfg_nxt.local_mac        = wr_data[MAC_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/nacp_parser.sv
`timescale 1ns / 1ps

module nacp_parser #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  nacp_pkg::in_item_t  item,
  input  nacp_pkg::cfg_regs_t cfg,
  output nacp_pkg::out_item_t result
);
  import nacp_pkg::*;

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int OW = $clog2(MAX_PACKET_BYTES + UNIT_BYTES * 255 + 1);

  logic [PW-1:0]    pos_r, pos_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [OW-1:0]    opt_start_r, opt_start_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [7:0]       units_r, units_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic             stop_r, stop_nxt;
  logic [1:0]       verdict_r, verdict_nxt;
  logic             sticky_r, sticky_nxt;

  logic             in_range;
  logic             in_hdr;
  logic             opt_active;
  logic [OW-1:0]    off_full;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] end_off;
  logic [3:0]       addr_idx;
  logic [2*ADDR_W-1:0] addr128;
  logic             hdr_check;
  logic [7:0]       hdr_expect;
  logic             short_pkt;

  assign in_range   = pos_r < PW'(MAX_PACKET_BYTES);
  assign in_hdr     = pos_r < PW'(HDR_BYTES);
  assign opt_active = hdr_ok_r && !stop_r && (OW'(pos_r) >= opt_start_r);
  assign off_full   = OW'(pos_r) - opt_start_r;
  assign off        = off_full[OFF_W-1:0];
  assign end_off    = {units_r, 3'b000} - OFF_W'(1);
  assign addr128    = {cfg.target_addr_high, cfg.target_addr_low};
  assign addr_idx   = 4'(5'(HDR_BYTES - 1) - pos_r[4:0]);

  always_comb begin
    hdr_check  = 1'b1;
    hdr_expect = addr128[{addr_idx, 3'b000} +: 8];
    if (pos_r == PW'(0)) begin
      hdr_expect = NA_TYPE;
    end else if (pos_r == PW'(1)) begin
      hdr_expect = NA_CODE;
    end else if (pos_r < PW'(8)) begin
      hdr_check = 1'b0;
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    hdr_ok_nxt    = hdr_ok_r;
    opt_start_nxt = opt_start_r;
    kind_nxt      = kind_r;
    units_nxt     = units_r;
    mac_nxt       = mac_r;
    stop_nxt      = stop_r;
    verdict_nxt   = verdict_r;
    sticky_nxt    = sticky_r;
    if (in_range) begin
      pos_nxt = pos_r + PW'(1);
      if (in_hdr) begin
        if (hdr_check && item.data_byte != hdr_expect) begin
          hdr_ok_nxt = 1'b0;
        end
      end else if (opt_active) begin
        if (off == OFF_W'(0)) begin
          kind_nxt = item.data_byte;
        end else if (off == OFF_W'(1)) begin
          units_nxt = item.data_byte;
          if (item.data_byte == 8'd0) begin
            stop_nxt = 1'b1;
          end
        end else begin
          if (off < OFF_W'(UNIT_BYTES) && kind_r == TLLA_KIND) begin
            mac_nxt = {mac_r[MAC_W-9:0], item.data_byte};
          end
          if (off == end_off) begin
            if (kind_r == TLLA_KIND) begin
              if (units_r == 8'd1 && mac_nxt == cfg.local_mac) begin
                verdict_nxt = VERDICT_OWN_MAC;
              end else begin
                verdict_nxt = VERDICT_CONFLICT;
                sticky_nxt  = 1'b1;
              end
              stop_nxt = 1'b1;
            end else begin
              opt_start_nxt = opt_start_r + OW'({units_r, 3'b000});
              if (opt_start_nxt >= OW'(MAX_PACKET_BYTES)) begin
                stop_nxt = 1'b1;
              end
              mac_nxt = '0;
            end
          end
        end
      end
    end
  end

  assign short_pkt = pos_r < PW'(HDR_BYTES - 1);

  always_comb begin
    result.peer_mac      = '0;
    result.conflict_seen = sticky_nxt;
    if (!hdr_ok_nxt || short_pkt) begin
      result.verdict = VERDICT_NOT_ADVERT;
    end else if (verdict_nxt == VERDICT_OWN_MAC || verdict_nxt == VERDICT_CONFLICT) begin
      result.verdict  = verdict_nxt;
      result.peer_mac = mac_nxt;
    end else begin
      result.verdict = VERDICT_NO_OPTION;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hdr_ok_r    <= 1'b1;
      opt_start_r <= OW'(HDR_BYTES);
      kind_r      <= '0;
      units_r     <= '0;
      mac_r       <= '0;
      stop_r      <= 1'b0;
      verdict_r   <= VERDICT_NOT_ADVERT;
      sticky_r    <= 1'b0;
    end else if (step_en) begin
      sticky_r <= sticky_nxt;
      if (item.last_byte) begin
        pos_r       <= '0;
        hdr_ok_r    <= 1'b1;
        opt_start_r <= OW'(HDR_BYTES);
        kind_r      <= '0;
        units_r     <= '0;
        mac_r       <= '0;
        stop_r      <= 1'b0;
        verdict_r   <= VERDICT_NOT_ADVERT;
      end else begin
        pos_r       <= pos_nxt;
        hdr_ok_r    <= hdr_ok_nxt;
        opt_start_r <= opt_start_nxt;
        kind_r      <= kind_nxt;
        units_r     <= units_nxt;
        mac_r       <= mac_nxt;
        stop_r      <= stop_nxt;
        verdict_r   <= verdict_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/neighbor_advert_conflict_parser.sv
`timescale 1ns / 1ps
// A last byte is loaded into the input register when it transfers in; when the parser steps
// on it, the parser outcome moves into the result register, from which the result is offered.
// Throughput: one byte per cycle; a last byte waits in the input register only while the
// previous result is still held by the receiver, and that stalls the input.
// Reset returns the parser to the start of a message and clears the sticky conflict flag,
// the configuration registers and both valid flags.

module neighbor_advert_conflict_parser #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic          clk,
  input  logic          rst_n,
  nacp_stream_if.sink   in_ch,
  nacp_stream_if.source out_ch,
  nacp_stream_if.sink   cfg_ch
);
  import nacp_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      step_en;
  logic      in_ready;
  cfg_regs_t cfg;
  cfg_item_t cfg_item;
  in_item_t  in_item;
  out_item_t result;

  assign cfg_item     = cfg_ch.payload;
  assign cfg_ch.ready = 1'b1;
  assign in_item      = in_ch.payload;

  nacp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_item.reg_index),
    .wr_data  (cfg_item.wr_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign step_en  = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_ready = !s1_valid_r || step_en;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  nacp_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && s1_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && s1_item_r.last_byte) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  a_ready_low_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_item_r.last_byte && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_item_r.last_byte))
    else $error("result raised without a last byte");

  a_no_mac_without_option: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.verdict == VERDICT_NOT_ADVERT ||
                     out_item_r.verdict == VERDICT_NO_OPTION)) |-> (out_item_r.peer_mac == '0))
    else $error("peer MAC reported without a target option");

  a_conflict_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.verdict == VERDICT_CONFLICT) |-> out_item_r.conflict_seen)
    else $error("conflict verdict without sticky flag");

endmodule
